FILE: rtl/ejscf_pkg.sv
// Shared types, register indexes and saturation helpers for the joint state filter.
package ejscf_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned MulAW     = 49;
  localparam int unsigned MulBW     = 32;
  localparam int unsigned MulPW     = MulAW + MulBW;
  localparam int unsigned MulCntW   = 6;

  typedef enum logic [CfgIdxW-1:0] {
    REG_JOINT_ENABLE  = 3'd0,
    REG_POS_SCALE     = 3'd1,
    REG_CMD_SCALE     = 3'd2,
    REG_INV_PERIOD    = 3'd3,
    REG_FILTER_ENABLE = 3'd4,
    REG_FILTER_ALPHA  = 3'd5
  } cfg_reg_t;

  localparam logic [16:0] INV_PERIOD_RST = 17'd1000;
  localparam logic [16:0] ALPHA_ONE      = 17'd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS_LD,
    S_POS_MUL,
    S_VEL_LD,
    S_VEL_MUL,
    S_ACC_LD,
    S_ACC_MUL,
    S_CMD_LD,
    S_CMD_MUL,
    S_FLT_LD,
    S_FLT_MUL,
    S_OUT
  } state_t;

  // Signed result from magnitude and sign, clamped to 32 bits.
  function automatic logic [31:0] sat32_mag(input logic [MulPW-1:0] m, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (m > MulPW'(64'h8000_0000)) r = 32'h8000_0000;
      else                           r = 32'(-m[31:0]);
    end else begin
      if (m > MulPW'(64'h7fff_ffff)) r = 32'h7fff_ffff;
      else                           r = m[31:0];
    end
    return r;
  endfunction

  // Signed result from magnitude and sign, clamped to 48 bits.
  function automatic logic [47:0] sat48_mag(input logic [MulPW-1:0] m, input logic neg);
    logic [47:0] r;
    if (neg) begin
      if (m > MulPW'(64'h8000_0000_0000)) r = 48'h8000_0000_0000;
      else                                r = 48'(-m[47:0]);
    end else begin
      if (m > MulPW'(64'h7fff_ffff_ffff)) r = 48'h7fff_ffff_ffff;
      else                                r = m[47:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/encoder_joint_state_and_command_filter_core.sv
// Joint state estimator and low-pass command filter built around a bit-serial multiplier.
//
// Input channel (in_valid/in_ready): one transaction per control tick, with an
// optional encoder sample and an optional new command position. Result channel
// (out_valid/out_ready): exactly one transaction per input, carrying position,
// velocity, acceleration and the filtered command in pulses.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high,
// only while the block is idle.
// All products go through one shared shift-and-add multiplier that retires one
// multiplier bit per cycle: a product is a load, 32 steps and a capture of the
// result, rounded except for velocity and acceleration. A tick runs up to five
// products (position, velocity, acceleration, command scale, filter step): none with
// the joint disabled, one for an unfiltered command-only tick, five for a full filtered tick.
// in_ready is high only while no tick is being computed; one tick is in work at
// a time. The finished result sits in an output register, so a stalled receiver
// holds only that register: the next tick is accepted and computed, and waits
// at the end until the output register frees up.
// Synchronous active-low reset clears the state, loads register defaults
// (period 1000 Hz, alpha 1.0) and arms seeding from the first encoder sample.
module encoder_joint_state_and_command_filter_core
  import ejscf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_sample_valid,
  input  logic signed [31:0]  in_sample_pulses,
  input  logic                in_command_valid,
  input  logic signed [31:0]  in_command_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_position,
  output logic signed [47:0]  out_velocity,
  output logic signed [47:0]  out_acceleration,
  output logic signed [31:0]  out_command_pulses,
  output logic                out_command_issued,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  // configuration
  logic        joint_en_r;
  logic [47:0] pos_scale_r;
  logic [40:0] cmd_scale_r;
  logic [16:0] inv_period_r;
  logic        filt_en_r;
  logic [16:0] alpha_r;

  // state
  logic [31:0] cur_pos_r, last_pos_r, held_r;
  logic [47:0] last_vel_r, cur_acc_r, vel_new_r, memory_r, cmd_val_r;
  logic        awaiting_r, primed_r;

  // latched transaction
  logic        in_cv_r;
  logic [31:0] in_pulses_r, in_cmd_r;

  // serial multiplier
  logic [MulAW-1:0]   mul_a_r;
  logic [MulPW-1:0]   mul_p_r;
  logic               mul_neg_r;
  logic [MulCntW-1:0] cnt_r;
  logic               mul_done;

  // output register
  logic        out_valid_r;
  logic [31:0] out_pos_r, out_cmd_r;
  logic [47:0] out_vel_r, out_acc_r;
  logic        out_iss_r;

  logic               accept, out_free, period_ok, is_load;
  logic signed [48:0] op_a;
  logic signed [32:0] op_b;
  logic [MulAW-1:0]   op_a_mag;
  logic [MulBW-1:0]   op_b_mag;
  logic [31:0]        held_sel;
  logic [16:0]        alpha_clamp;
  logic [49:0]        step_sum;
  logic [MulPW:0]     rnd16, rnd24;
  logic [48:0]        flt_sum;
  logic [47:0]        mem_mag;
  logic [48:0]        mem_rnd;
  logic [31:0]        cmd_out;
  logic               issue_now;

  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign period_ok   = (inv_period_r != 17'd0);
  assign mul_done    = cnt_r[MulCntW-1];
  assign held_sel    = in_cv_r ? in_cmd_r : held_r;
  assign alpha_clamp = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!joint_en_r)          state_nxt = S_OUT;
          else if (in_sample_valid) state_nxt = S_POS_LD;
          else                      state_nxt = S_CMD_LD;
        end
      end
      S_POS_LD:  state_nxt = S_POS_MUL;
      S_POS_MUL: begin
        if (mul_done) state_nxt = (period_ok && !awaiting_r) ? S_VEL_LD : S_CMD_LD;
      end
      S_VEL_LD:  state_nxt = S_VEL_MUL;
      S_VEL_MUL: if (mul_done) state_nxt = S_ACC_LD;
      S_ACC_LD:  state_nxt = S_ACC_MUL;
      S_ACC_MUL: if (mul_done) state_nxt = S_CMD_LD;
      S_CMD_LD:  state_nxt = awaiting_r ? S_OUT : S_CMD_MUL;
      S_CMD_MUL: begin
        if (mul_done) state_nxt = (filt_en_r && period_ok && primed_r) ? S_FLT_LD : S_OUT;
      end
      S_FLT_LD:  state_nxt = S_FLT_MUL;
      S_FLT_MUL: if (mul_done) state_nxt = S_OUT;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // state outputs and operand select
  always_comb begin
    in_ready = 1'b0;
    is_load  = 1'b0;
    op_a     = '0;
    op_b     = '0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_POS_LD: begin
        is_load = 1'b1;
        op_a    = {pos_scale_r[47], pos_scale_r};
        op_b    = {in_pulses_r[31], in_pulses_r};
      end
      S_VEL_LD: begin
        is_load = 1'b1;
        op_a    = {{17{cur_pos_r[31]}}, cur_pos_r} - {{17{last_pos_r[31]}}, last_pos_r};
        op_b    = {16'd0, inv_period_r};
      end
      S_ACC_LD: begin
        is_load = 1'b1;
        op_a    = {vel_new_r[47], vel_new_r} - {last_vel_r[47], last_vel_r};
        op_b    = {16'd0, inv_period_r};
      end
      S_CMD_LD: begin
        is_load = !awaiting_r;
        op_a    = {{8{cmd_scale_r[40]}}, cmd_scale_r};
        op_b    = {held_sel[31], held_sel};
      end
      S_FLT_LD: begin
        is_load = 1'b1;
        op_a    = {cmd_val_r[47], cmd_val_r} - {memory_r[47], memory_r};
        op_b    = {16'd0, alpha_clamp};
      end
      default: ;
    endcase
  end

  assign op_a_mag = op_a[48] ? MulAW'(-op_a) : MulAW'(op_a);
  assign op_b_mag = op_b[32] ? MulBW'(-op_b) : MulBW'(op_b);

  // one multiplier bit per cycle: add the multiplicand into the upper half, shift right
  assign step_sum = {1'b0, mul_p_r[MulPW-1:MulBW]} + (mul_p_r[0] ? {1'b0, mul_a_r} : 50'd0);

  assign rnd16 = {1'b0, mul_p_r} + (MulPW+1)'(1 << 15);
  assign rnd24 = {1'b0, mul_p_r} + (MulPW+1)'(1 << 23);

  assign flt_sum = {memory_r[47], memory_r}
                 + (mul_neg_r ? 49'(-rnd16[64:16]) : rnd16[64:16]);

  // command output: memory / 2^16 rounded half away from zero
  assign mem_mag   = memory_r[47] ? 48'(-memory_r) : memory_r;
  assign mem_rnd   = {1'b0, mem_mag} + 49'(1 << 15);
  assign cmd_out   = sat32_mag(MulPW'(mem_rnd[48:16]), memory_r[47]);
  assign issue_now = joint_en_r && !awaiting_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_en_r   <= 1'b0;
      pos_scale_r  <= '0;
      cmd_scale_r  <= '0;
      inv_period_r <= INV_PERIOD_RST;
      filt_en_r    <= 1'b0;
      alpha_r      <= ALPHA_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_JOINT_ENABLE:  joint_en_r   <= cfg_wdata[0];
        REG_POS_SCALE:     pos_scale_r  <= cfg_wdata[47:0];
        REG_CMD_SCALE:     cmd_scale_r  <= cfg_wdata[40:0];
        REG_INV_PERIOD:    inv_period_r <= cfg_wdata[16:0];
        REG_FILTER_ENABLE: filt_en_r    <= cfg_wdata[0];
        REG_FILTER_ALPHA:  alpha_r      <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // datapath and joint state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pos_r   <= '0;
      last_pos_r  <= '0;
      last_vel_r  <= '0;
      cur_acc_r   <= '0;
      held_r      <= '0;
      memory_r    <= '0;
      awaiting_r  <= 1'b1;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;

      if (accept) begin
        in_cv_r     <= in_command_valid;
        in_pulses_r <= in_sample_pulses;
        in_cmd_r    <= in_command_position;
      end

      if (is_load) begin
        mul_a_r   <= op_a_mag;
        mul_p_r   <= {{MulAW{1'b0}}, op_b_mag};
        mul_neg_r <= op_a[48] ^ op_b[32];
        cnt_r     <= '0;
      end else if (!mul_done) begin
        mul_p_r <= {step_sum, mul_p_r[MulBW-1:1]};
        cnt_r   <= cnt_r + 1'b1;
      end

      unique case (state_r)
        S_POS_MUL: begin
          if (mul_done) begin
            cur_pos_r <= sat32_mag(MulPW'(rnd24[MulPW:24]), mul_neg_r);
            // differencing needs the old last position; hold it until velocity is done
            if (!(period_ok && !awaiting_r)) begin
              last_pos_r <= sat32_mag(MulPW'(rnd24[MulPW:24]), mul_neg_r);
            end
            if (awaiting_r) begin
              held_r     <= sat32_mag(MulPW'(rnd24[MulPW:24]), mul_neg_r);
              awaiting_r <= 1'b0;
            end
          end
        end
        S_VEL_MUL: begin
          if (mul_done) begin
            vel_new_r  <= sat48_mag(mul_p_r, mul_neg_r);
            last_pos_r <= cur_pos_r;
          end
        end
        S_ACC_MUL: begin
          if (mul_done) begin
            cur_acc_r  <= sat48_mag(mul_p_r, mul_neg_r);
            last_vel_r <= vel_new_r;
          end
        end
        S_CMD_LD: held_r <= held_sel;
        S_CMD_MUL: begin
          if (mul_done) begin
            cmd_val_r <= sat48_mag(MulPW'(rnd16[MulPW:16]), mul_neg_r);
            // pass through when bypassed or on the first filtered tick
            if (!(filt_en_r && period_ok && primed_r)) begin
              memory_r <= sat48_mag(MulPW'(rnd16[MulPW:16]), mul_neg_r);
              if (filt_en_r && period_ok) primed_r <= 1'b1;
            end
          end
        end
        S_FLT_MUL: if (mul_done) memory_r <= flt_sum[47:0];
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= cur_pos_r;
            out_vel_r   <= last_vel_r;
            out_acc_r   <= cur_acc_r;
            out_cmd_r   <= issue_now ? cmd_out : 32'd0;
            out_iss_r   <= issue_now;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position       = out_pos_r;
  assign out_velocity       = out_vel_r;
  assign out_acceleration   = out_acc_r;
  assign out_command_pulses = out_cmd_r;
  assign out_command_issued = out_iss_r;

endmodule

FILE: verif/tb_top.sv
// Testbench for the joint state estimator and command filter core: directed table, random phases.
module tb_top;
  import ejscf_pkg::*;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [47:0] velocity;
    logic signed [47:0] acceleration;
    logic signed [31:0] command_pulses;
    logic               command_issued;
  } joint_result_t;

  typedef struct {
    bit            enable_before;
    bit            sample_valid;
    int            sample_pulses;
    bit            command_valid;
    int            command_position;
    bit            typed;
    joint_result_t want;
  } tick_row_t;

  localparam longint SAT48_HI = (64'sd1 <<< 47) - 1;
  localparam longint SAT48_LO = -(64'sd1 <<< 47);
  localparam int     CYCLE_LIMIT = 3000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_sample_valid;
  logic signed [31:0]  in_sample_pulses;
  logic                in_command_valid;
  logic signed [31:0]  in_command_position;
  logic                out_valid;
  logic                out_ready;
  logic signed [31:0]  out_position;
  logic signed [47:0]  out_velocity;
  logic signed [47:0]  out_acceleration;
  logic signed [31:0]  out_command_pulses;
  logic                out_command_issued;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  encoder_joint_state_and_command_filter_core dut (.*);

  // register shadow
  bit                 joint_on;
  logic signed [47:0] pos_scale;
  logic signed [40:0] cmd_scale;
  logic [16:0]        inv_period;
  bit                 filter_on;
  logic [16:0]        alpha;

  // estimator state
  longint cur_pos, last_pos, last_vel, cur_acc, held_cmd, filt_mem;
  bit     await_first, filt_primed;

  joint_result_t expected_results[$];
  tick_row_t     dir_rows[$];
  int            errors = 0;
  int            cycles = 0;
  int            send_idle_pct, recv_idle_pct;
  int            walk_pulses;

  function automatic longint sat_to(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // a*b/2^s, rounded half away from zero
  function automatic longint scale_round(longint a, longint b, int s);
    longint unsigned ua, ub, r, m;
    ua = magnitude(a);
    ub = magnitude(b);
    m  = (64'd1 << s) - 1;
    r  = (ua >> s) * ub + (((ua & m) * ub + (64'd1 << (s - 1))) >> s);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint rate_sat48(longint a, longint unsigned b);
    longint unsigned ua;
    ua = magnitude(a);
    if (b != 0 && ua > (64'd1 << 47) / b) return a < 0 ? SAT48_LO : SAT48_HI;
    return sat_to(a < 0 ? -longint'(ua * b) : longint'(ua * b), 48);
  endfunction

  function automatic joint_result_t estimate_tick(bit sv, int sp, bit cv, int cp);
    joint_result_t r;
    longint pos, vel, cmd, cmd_out, a;
    bit issued;
    cmd_out = 0;
    issued  = 0;
    if (joint_on) begin
      if (sv) begin
        pos = sat_to(scale_round(longint'(pos_scale), longint'(sp), 24), 32);
        cur_pos = pos;
        if (inv_period != 0 && !await_first) begin
          vel      = rate_sat48(pos - last_pos, inv_period);
          cur_acc  = rate_sat48(vel - last_vel, inv_period);
          last_vel = vel;
        end
        last_pos = pos;
        if (await_first) begin
          held_cmd    = pos;
          filt_mem    = longint'(sp) * 65536;
          await_first = 0;
        end
      end
      if (cv) held_cmd = cp;
      if (!await_first) begin
        cmd = sat_to(scale_round(longint'(cmd_scale), held_cmd, 16), 48);
        if (!filter_on || inv_period == 0) begin
          filt_mem = cmd;
        end else if (!filt_primed) begin
          filt_mem    = cmd;
          filt_primed = 1;
        end else begin
          a = (alpha > 17'd65536) ? 65536 : longint'(alpha);
          filt_mem = filt_mem + scale_round(cmd - filt_mem, a, 16);
        end
        cmd_out = sat_to(scale_round(filt_mem, 1, 16), 32);
        issued  = 1;
      end
    end
    r.position       = cur_pos[31:0];
    r.velocity       = last_vel[47:0];
    r.acceleration   = cur_acc[47:0];
    r.command_pulses = cmd_out[31:0];
    r.command_issued = issued;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [47:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      REG_JOINT_ENABLE:  joint_on   = data[0];
      REG_POS_SCALE:     pos_scale  = data[47:0];
      REG_CMD_SCALE:     cmd_scale  = data[40:0];
      REG_INV_PERIOD:    inv_period = data[16:0];
      REG_FILTER_ENABLE: filter_on  = data[0];
      REG_FILTER_ALPHA:  alpha      = data[16:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // hold until every result is back, then let the core settle
  task automatic drain();
    wait (expected_results.size() == 0);
    repeat (200) @(negedge clk);
  endtask

  task automatic send_tick(bit sv, int sp, bit cv, int cp, bit typed, joint_result_t want);
    joint_result_t pred;
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid            = 1'b1;
    in_sample_valid     = sv;
    in_sample_pulses    = sp;
    in_command_valid    = cv;
    in_command_position = cp;
    do @(posedge clk); while (!in_ready);
    pred = estimate_tick(sv, sp, cv, cp);
    expected_results.push_back(typed ? want : pred);
    // drop valid so the transaction is not taken twice
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic int pick_pulses();
    if ($urandom_range(0, 3) == 0) return $urandom;
    walk_pulses += $urandom_range(0, 2000) - 1000;
    return walk_pulses;
  endfunction

  function automatic logic [47:0] pick_pos_scale();
    case ($urandom_range(0, 5))
      0: return 48'h7fff_ffff_ffff;
      1: return 48'h8000_0000_0000;
      2: return 48'({$urandom, $urandom});
      3: return -(48'd1 << 40);
      default: return (48'd1 << 40) + 48'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [47:0] pick_cmd_scale();
    case ($urandom_range(0, 4))
      0: return 48'h0ff_ffff_ffff;
      1: return 48'h100_0000_0000;
      2: return 48'({$urandom, $urandom} & 64'h1ff_ffff_ffff);
      3: return -(48'd1 << 16);
      default: return 48'(65536 + $urandom_range(0, 4096));
    endcase
  endfunction

  function automatic logic [47:0] pick_period();
    case ($urandom_range(0, 5))
      0: return 48'd0;
      1: return 48'd1;
      2: return 48'd100000;
      3: return 48'd131071;
      default: return 48'($urandom_range(1, 2000));
    endcase
  endfunction

  function automatic logic [47:0] pick_alpha();
    case ($urandom_range(0, 4))
      0: return 48'd0;
      1: return 48'd65536;
      2: return 48'd131071;
      default: return 48'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("encoder_joint_state_and_command_filter_core test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n ? ($urandom_range(0, 99) >= recv_idle_pct) : 1'b0;
  end

  always @(posedge clk) begin
    joint_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_position !== want.position)
          report("position", out_position, want.position);
        if (out_velocity !== want.velocity)
          report("velocity", out_velocity, want.velocity);
        if (out_acceleration !== want.acceleration)
          report("acceleration", out_acceleration, want.acceleration);
        if (out_command_pulses !== want.command_pulses)
          report("command_pulses", out_command_pulses, want.command_pulses);
        if (out_command_issued !== want.command_issued)
          report("command_issued", out_command_issued, want.command_issued);
      end
    end
  end

  initial begin
    joint_result_t none;
    int n;
    none = '0;
    walk_pulses = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_valid = 1'b0;
    in_sample_pulses = '0;
    in_command_valid = 1'b0;
    in_command_position = '0;
    cfg_we = 1'b0;
    cfg_index = REG_JOINT_ENABLE;
    cfg_wdata = '0;
    joint_on = 0; pos_scale = '0; cmd_scale = '0; inv_period = 17'd1000;
    filter_on = 0; alpha = 17'd65536;
    cur_pos = 0; last_pos = 0; last_vel = 0; cur_acc = 0; held_cmd = 0; filt_mem = 0;
    await_first = 1; filt_primed = 0;

    // disabled joint, then commands before the first sample, then seeding
    dir_rows.push_back('{0, 1, 100, 1, 7, 1, none});
    dir_rows.push_back('{1, 0, 0, 1, 65536, 1, none});
    dir_rows.push_back('{0, 0, 0, 0, 0, 1, none});
    dir_rows.push_back('{0, 1, 5, 0, 0, 1, joint_result_t'{32'sd327680, 48'sd0, 48'sd0,
                                                           32'sd5, 1'b1}});
    dir_rows.push_back('{0, 1, 6, 0, 0, 1, joint_result_t'{32'sd393216, 48'sd65536000,
                                                           48'sd65536000000, 32'sd5, 1'b1}});
    dir_rows.push_back('{0, 1, 32'h7fff_ffff, 0, 0, 0, none});
    dir_rows.push_back('{0, 1, 32'h8000_0000, 0, 0, 0, none});
    dir_rows.push_back('{0, 1, 0, 1, 32'h7fff_ffff, 0, none});
    dir_rows.push_back('{0, 1, -1, 1, 32'h8000_0000, 0, none});
    dir_rows.push_back('{0, 0, 0, 1, 1, 0, none});
    dir_rows.push_back('{0, 0, 0, 1, -1, 0, none});
    dir_rows.push_back('{0, 1, 32'h5555_5555, 1, 32'haaaa_aaaa, 0, none});
    dir_rows.push_back('{0, 1, 32'haaaa_aaaa, 1, 32'h5555_5555, 0, none});
    dir_rows.push_back('{0, 0, 0, 0, 0, 0, none});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].enable_before) begin
        drain();
        write_reg(REG_POS_SCALE, 48'd1 << 40);
        write_reg(REG_CMD_SCALE, 48'd1 << 16);
        write_reg(REG_JOINT_ENABLE, 48'd1);
      end
      send_tick(dir_rows[i].sample_valid, dir_rows[i].sample_pulses,
                dir_rows[i].command_valid, dir_rows[i].command_position,
                dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      send_idle_pct = (ph < 3) ? 21 : (ph < 6) ? 59 : 0;
      recv_idle_pct = (ph < 3) ? 59 : (ph < 6) ? 21 : 0;
      write_reg(REG_JOINT_ENABLE, (ph == 7) ? 48'd0 : 48'd1);
      write_reg(REG_POS_SCALE, pick_pos_scale());
      write_reg(REG_CMD_SCALE, pick_cmd_scale());
      write_reg(REG_INV_PERIOD, pick_period());
      write_reg(REG_FILTER_ENABLE, (ph % 3 != 0) ? 48'd1 : 48'd0);
      write_reg(REG_FILTER_ALPHA, pick_alpha());
      n = (ph == 7) ? 40 : 250;
      for (int k = 0; k < n; k++) begin
        // hold off until the core has handed back everything
        if (ph == 4 && k == n / 2) wait (expected_results.size() == 0);
        send_tick($urandom_range(0, 3) != 0, pick_pulses(),
                  1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0) ? int'($urandom)
                  : int'($urandom_range(0, 1 << 20)) - (1 << 19), 1'b0, none);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_results.size() == 0);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("encoder_joint_state_and_command_filter_core test passed");
    end else begin
      $display("encoder_joint_state_and_command_filter_core test failed");
    end
    $finish;
  end

endmodule
